@@ rtl/frwl_pkg.sv @@
package frwl_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Grants that may follow one transaction
    localparam int MAX_GRANTS  = 16;
    localparam int GCNT_W      = $clog2(MAX_GRANTS + 1);

    // Field widths
    localparam int ID_W        = 4;
    localparam int RD_W        = 5;
    localparam logic [RD_W-1:0] READERS_MAX = 5'd31;

    typedef enum logic [1:0] {
        REQ_READ_LOCK    = 2'd0,
        REQ_READ_UNLOCK  = 2'd1,
        REQ_WRITE_LOCK   = 2'd2,
        REQ_WRITE_UNLOCK = 2'd3
    } req_type_t;

    typedef enum logic [2:0] {
        ST_GRANT      = 3'd0,
        ST_QUEUED     = 3'd1,
        ST_RELEASED   = 3'd2,
        ST_UNLOCK_ERR = 3'd3,
        ST_FULL       = 3'd4
    } status_t;

    typedef enum logic {
        FSM_IDLE = 1'b0,
        FSM_WALK = 1'b1
    } fsm_t;

    // One queued lock request
    typedef struct packed {
        logic            is_write;
        logic [ID_W-1:0] id;
    } entry_t;

    // Per-cell control from the queue controller
    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

endpackage

@@ rtl/frwl_cell.sv @@
module frwl_cell import frwl_pkg::*; (
    input  logic       aclk,
    input  cell_ctrl_t ctrl,
    input  entry_t     new_entry,
    input  entry_t     upstream,
    output entry_t     entry
);

    entry_t entry_reg;

    // Load the tail entry, or take the neighbor's entry when the head pops
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            entry_reg <= new_entry;
        end else if (ctrl.shift) begin
            entry_reg <= upstream;
        end
    end

    assign entry = entry_reg;

endmodule

@@ rtl/fifo_reader_writer_lock_arbiter.sv @@
// Channel   Ports                                          Direction
// s_        s_valid s_ready s_req_type s_requester_id     request in
// m_        m_valid m_ready m_status m_agent_id           result out
//           m_grant_is_write m_last
//
// A transaction is taken when s_valid meets s_ready; its acknowledgement and each grant that
// follows then leave through the output register at one result per cycle while m_ready
// does not stall, set by the single grant walk over the head cell of the queue. The next
// request is taken once the last result has moved to the output register.
// Reset (aresetn low, synchronous) empties the queue and frees the lock.
// A stall on m_ready freezes the walk; the output register holds its result.
module fifo_reader_writer_lock_arbiter import frwl_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [1:0]      s_req_type,
    input  logic [ID_W-1:0] s_requester_id,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [2:0]      m_status,
    output logic [ID_W-1:0] m_agent_id,
    output logic            m_grant_is_write,
    output logic            m_last
);

    fsm_t              state_reg, state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [RD_W-1:0]   readers_reg;
    logic              writer_reg;
    logic [GCNT_W-1:0] gcnt_reg;

    // Result waiting for the output register
    status_t           hold_status_reg;
    logic [ID_W-1:0]   hold_id_reg;
    logic              hold_wr_reg;

    logic              out_valid_reg;
    status_t           out_status_reg;
    logic [ID_W-1:0]   out_id_reg;
    logic              out_wr_reg;
    logic              out_last_reg;

    logic              do_accept, do_move, do_grant, grant_ok, out_free;
    req_type_t         req;
    entry_t            new_entry;
    entry_t            head;
    entry_t            cell_q [QUEUE_DEPTH];
    cell_ctrl_t        cell_ctrl [QUEUE_DEPTH];

    assign req       = req_type_t'(s_req_type);
    assign new_entry = '{is_write: s_req_type[1], id: s_requester_id};
    assign head      = cell_q[0];
    assign out_free  = !out_valid_reg || m_ready;

    // Head of the queue may be granted now
    always_comb begin
        grant_ok = (count_reg != '0) && !writer_reg && (gcnt_reg < GCNT_W'(MAX_GRANTS));
        if (head.is_write) begin
            grant_ok = grant_ok && (readers_reg == '0);
        end else begin
            grant_ok = grant_ok && (readers_reg != READERS_MAX);
        end
    end

    // Control outputs of the state machine
    always_comb begin
        s_ready   = (state_reg == FSM_IDLE);
        do_accept = s_ready && s_valid;
        do_move   = (state_reg == FSM_WALK) && out_free;
        do_grant  = do_move && grant_ok;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE: begin
                if (s_valid) state_next = FSM_WALK;
            end
            FSM_WALK: begin
                if (out_free && !grant_ok) state_next = FSM_IDLE;
            end
            default: state_next = FSM_IDLE;
        endcase
    end

    // Chain of queue cells, cell 0 is the head
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        entry_t up;
        if (i == QUEUE_DEPTH - 1) begin : g_end
            assign up = '0;
        end else begin : g_mid
            assign up = cell_q[i+1];
        end
        assign cell_ctrl[i].load  = do_accept && !req[0] &&
                                    (count_reg == CNT_W'(i));
        assign cell_ctrl[i].shift = do_grant;
        frwl_cell u_cell (
            .aclk      (aclk),
            .ctrl      (cell_ctrl[i]),
            .new_entry (new_entry),
            .upstream  (up),
            .entry     (cell_q[i])
        );
    end

    // Lock state, acknowledgement and grant walk
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FSM_IDLE;
            count_reg   <= '0;
            readers_reg <= '0;
            writer_reg  <= 1'b0;
            gcnt_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (do_accept) begin
                gcnt_reg    <= '0;
                hold_id_reg <= s_requester_id;
                hold_wr_reg <= s_req_type[1];
                unique case (req)
                    REQ_READ_LOCK, REQ_WRITE_LOCK: begin
                        if (count_reg == CNT_W'(QUEUE_DEPTH)) begin
                            hold_status_reg <= ST_FULL;
                        end else begin
                            count_reg       <= count_reg + 1'b1;
                            hold_status_reg <= ST_QUEUED;
                        end
                    end
                    REQ_READ_UNLOCK: begin
                        if (readers_reg == '0) begin
                            hold_status_reg <= ST_UNLOCK_ERR;
                        end else begin
                            readers_reg     <= readers_reg - 1'b1;
                            hold_status_reg <= ST_RELEASED;
                        end
                    end
                    REQ_WRITE_UNLOCK: begin
                        if (!writer_reg) begin
                            hold_status_reg <= ST_UNLOCK_ERR;
                        end else begin
                            writer_reg      <= 1'b0;
                            hold_status_reg <= ST_RELEASED;
                        end
                    end
                    default: hold_status_reg <= ST_UNLOCK_ERR;
                endcase
            end else if (do_grant) begin
                count_reg       <= count_reg - 1'b1;
                gcnt_reg        <= gcnt_reg + 1'b1;
                hold_status_reg <= ST_GRANT;
                hold_id_reg     <= head.id;
                hold_wr_reg     <= head.is_write;
                if (head.is_write) begin
                    writer_reg <= 1'b1;
                end else begin
                    readers_reg <= readers_reg + 1'b1;
                end
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (do_move) begin
            out_valid_reg  <= 1'b1;
            out_status_reg <= hold_status_reg;
            out_id_reg     <= hold_id_reg;
            out_wr_reg     <= hold_wr_reg;
            out_last_reg   <= !grant_ok;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_status         = out_status_reg;
    assign m_agent_id       = out_id_reg;
    assign m_grant_is_write = out_wr_reg;
    assign m_last           = out_last_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(writer_reg && (readers_reg != '0)))
        else $error("writer and readers hold the lock together");

    a_walk_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == FSM_WALK))
        else $error("accepted transaction not walked");

    a_grant_not_last_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        do_grant |=> (m_valid && !m_last))
        else $error("result before a grant marked last");
`endif

endmodule
